### hdl/mavg_pkg.sv
// package for the moving average window core
// holds parameter defaults shared by the core and its checker
// no dependencies
package mavg_pkg;

  localparam int unsigned WINDOW_DEF      = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

endpackage

### hdl/mavg_ram.sv
// generic single write port, single read port ram with registered read
// width and depth set by parameters
// no dependencies
module mavg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/mavg_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// unsigned numerator and denominator, quotient held until the next start
// no dependencies
module mavg_div #(
  parameter int unsigned NUM_W = 20,
  parameter int unsigned DEN_W = 5,
  localparam int unsigned CW   = $clog2(NUM_W + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fit;

  // next remainder bit comes from the top of the numerator shift register
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fit     = ~diff[DEN_W];

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CW'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fit};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### hdl/moving_average_window_core.sv
// moving average over the last WINDOW signed samples
// uses mavg_pkg, mavg_ram and mavg_div
//
//   channel   signals                       beat carries
//   input     in_valid_i / in_stall_o       sample_i, signed SAMPLE_BITS
//   output    out_valid_o / out_stall_i     average_o, signed SAMPLE_BITS
//
// the bit-serial divider works one quotient bit per cycle
// the result beat is offered once the division is done and the output is free
// items are worked one at a time; a new beat is taken while a result waits
// reset clears the fill count, write slot and running sum; the ring is not cleared
// a stalled result holds the block in its last step until the output frees
module moving_average_window_core
  import mavg_pkg::*;
#(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] average_o
);

  localparam int unsigned POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(WINDOW);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [POS_W-1:0]              wpos_q, wpos_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          neg_q;
  logic                          out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]        average_q, average_d;

  logic                          in_acc;
  logic                          out_free;
  logic                          full;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic                          div_start;
  logic                          div_done;
  logic [SUM_W-1:0]              div_num;
  logic [SUM_W-1:0]              div_quot;
  logic [SUM_W-1:0]              quot_signed;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign full       = (cnt_q == CNT_W'(WINDOW));
  assign old_sample = signed'(ram_rdata);

  // ring read address follows the write slot, so the oldest entry is ready by the sum step
  mavg_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(WINDOW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_SUM),
    .waddr_i(wpos_q),
    .wdata_i(sample_q),
    .raddr_i(wpos_q),
    .rdata_o(ram_rdata)
  );

  assign div_start = (state_q == ST_SUM);
  assign div_num   = sum_d[SUM_W-1] ? (SUM_W'(0) - sum_d) : sum_d;

  mavg_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (cnt_d),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // truncation toward zero: divide magnitudes, then restore the sign
  assign quot_signed = neg_q ? (SUM_W'(0) - div_quot) : div_quot;

  always_comb begin
    state_d     = state_q;
    wpos_d      = wpos_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q & out_stall_i;
    average_d   = average_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (full) begin
          sum_d = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
        end else begin
          sum_d = sum_q + SUM_W'(sample_q);
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (wpos_q == POS_W'(WINDOW - 1)) begin
          wpos_d = '0;
        end else begin
          wpos_d = wpos_q + POS_W'(1);
        end
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          average_d   = quot_signed[SAMPLE_BITS-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wpos_q      <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wpos_q      <= wpos_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= signed'(sample_i);
    end
    if (state_q == ST_SUM) begin
      neg_q <= sum_d[SUM_W-1];
    end
    average_q <= average_d;
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;

endmodule

### hdl/mavg_checker.sv
// port-level checker for moving_average_window_core
// uses mavg_pkg; bound to the core at the end of this file
module mavg_checker
  import mavg_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic [SAMPLE_BITS-1:0] sample_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [SAMPLE_BITS-1:0] average_o
);

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(sample_i))
    else $error("stalled input beat changed");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(average_o))
    else $error("stalled result beat changed");

  // an accepted beat keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // the block only leaves idle on an offered beat
  a_busy_from_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("busy without an input beat");

  // a result appears only at the end of item work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without item work");

endmodule

bind moving_average_window_core mavg_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_mavg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .sample_i   (sample_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .average_o  (average_o)
);

### test/moving_average_window_core_test.sv
// testbench for moving_average_window_core, checked against a running-mean predictor
// a directed table comes first, then random runs, with random input gaps and output stalls
// depends on hdl/mavg_pkg.sv and the core with its ram and divider
module moving_average_window_core_test
  import mavg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN     = WINDOW_DEF;
  localparam int unsigned SBITS   = SAMPLE_BITS_DEF;
  localparam int          RANDOM_SAMPLES = 500;
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          MAX_REPORTS    = 10;

  typedef logic [SBITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    known;
    sample_t mean;
  } stim_row_t;

  // first rows follow reset, so their means are easy to work out by hand
  localparam int NUM_ROWS = 25;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{16'h7fff, 1'b1, 16'h7fff},
    '{16'h8000, 1'b1, 16'h0000},  // sum of -1 over two truncates to zero
    '{16'h8000, 1'b1, 16'hd555},
    '{16'h0000, 1'b0, 16'h0000},
    '{16'h0001, 1'b0, 16'h0000},
    '{16'hffff, 1'b0, 16'h0000},
    '{16'h0002, 1'b0, 16'h0000},
    '{16'hfffe, 1'b0, 16'h0000},
    '{16'h7ffe, 1'b0, 16'h0000},
    '{16'h8001, 1'b0, 16'h0000},
    '{16'h5555, 1'b0, 16'h0000},
    '{16'haaaa, 1'b0, 16'h0000},
    '{16'h00ff, 1'b0, 16'h0000},
    '{16'hff00, 1'b0, 16'h0000},
    '{16'h1234, 1'b0, 16'h0000},
    '{16'hedcc, 1'b0, 16'h0000},
    '{16'h7fff, 1'b0, 16'h0000},  // window full from here, oldest drops out
    '{16'h7fff, 1'b0, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000},
    '{16'h0000, 1'b0, 16'h0000},
    '{16'hffff, 1'b0, 16'h0000},
    '{16'h0001, 1'b0, 16'h0000},
    '{16'h4000, 1'b0, 16'h0000},
    '{16'hc000, 1'b0, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000}
  };

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_stall_o;
  sample_t sample_i    = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  sample_t average_o;

  moving_average_window_core #(
    .WINDOW     (WIN),
    .SAMPLE_BITS(SBITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .average_o  (average_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // predictor state: ring of past samples, next slot, samples held, exact sum
  logic signed [SBITS-1:0] ring_hist [WIN];
  int                      slot_nxt  = 0;
  int                      held_cnt  = 0;
  int                      hist_sum  = 0;

  sample_t mean_q [$];
  int      bad_cnt = 0;

  function automatic sample_t window_mean(input sample_t x);
    logic signed [SBITS-1:0] sx;
    int                      mean;
    sx = $signed(x);
    if (held_cnt >= WIN) hist_sum -= int'(ring_hist[slot_nxt]);
    else held_cnt++;
    ring_hist[slot_nxt] = sx;
    hist_sum += int'(sx);
    // int division truncates toward zero
    mean = hist_sum / held_cnt;
    slot_nxt = (slot_nxt == WIN - 1) ? 0 : slot_nxt + 1;
    return sample_t'(mean);
  endfunction

  // one input beat: optional gap, then hold valid until accepted
  task automatic send_sample(input sample_t x, input logic known, input sample_t typed);
    int      r;
    int      gap;
    sample_t pred;
    r = $urandom_range(0, 99);
    gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= x;
    do @(posedge clk_i); while (in_stall_o);
    pred = window_mean(x);
    mean_q.push_back(known ? typed : pred);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (mean_q.size() != 0);
  endtask

  // output stall: short and long stalls, and long calm stretches
  int stall_left = 0;
  always @(posedge clk_i) begin
    int r;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall_i <= 1'b0;
        stall_left  <= $urandom_range(1, 10);
      end else if (r < 65) begin
        out_stall_i <= 1'b0;
        stall_left  <= $urandom_range(50, 300);
      end else if (r < 90) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(1, 4);
      end else begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(10, 40);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    sample_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mean_q.size() == 0) begin
        if (bad_cnt < MAX_REPORTS)
          $display("unexpected result beat: average %0d", $signed(average_o));
        bad_cnt++;
      end else begin
        want = mean_q.pop_front();
        if (average_o !== want) begin
          if (bad_cnt < MAX_REPORTS)
            $display("average mismatch: expected %0d got %0d", $signed(want),
                     $signed(average_o));
          bad_cnt++;
        end
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL moving_average_window_core");
    $finish;
  end

  initial begin
    int      fed;
    int      r;
    int      len;
    sample_t v;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++)
      send_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].mean);
    drain_results();

    fed = 0;
    while (fed < RANDOM_SAMPLES) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) send_sample(sample_t'($urandom()), 1'b0, '0);
      end else if (r < 70) begin
        // a full window of one extreme gives that extreme back
        len = $urandom_range(WIN, WIN + 4);
        v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        for (int i = 0; i < len; i++) send_sample(v, 1'b0, '0);
      end else if (r < 82) begin
        // small values around zero exercise truncation of negative means
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++)
          send_sample(sample_t'($urandom_range(0, 8) - 4), 1'b0, '0);
      end else if (r < 95) begin
        len = $urandom_range(2, 20);
        for (int i = 0; i < len; i++)
          send_sample((i % 2 == 0) ? 16'h7fff : 16'h8000, 1'b0, '0);
      end else begin
        len = 0;
        drain_results();
      end
      fed += len;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_cnt == 0) begin
      $display("PASS moving_average_window_core");
    end else begin
      $display("FAIL moving_average_window_core");
    end
    $finish;
  end

endmodule

### moving_average_window_core.f
hdl/mavg_pkg.sv
hdl/mavg_ram.sv
hdl/mavg_div.sv
hdl/moving_average_window_core.sv
hdl/mavg_checker.sv
test/moving_average_window_core_test.sv
